// File: design/fhm_pkg.sv
// ----------------------------------------------------------------------------
// fhm_pkg
// Shared types and constants for the fan health monitor.
// ----------------------------------------------------------------------------
package fhm_pkg;

  // input kinds
  localparam logic [1:0] KIND_INT_TEMP = 2'd0;
  localparam logic [1:0] KIND_EXT_TEMP = 2'd1;
  localparam logic [1:0] KIND_TACH     = 2'd2;
  localparam logic [1:0] KIND_BUS_FAIL = 2'd3;

  // register indexes
  localparam logic [1:0] REG_LEVEL   = 2'd0;
  localparam logic [1:0] REG_INT_LIM = 2'd1;
  localparam logic [1:0] REG_EXT_LIM = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 20;

  localparam logic [19:0]        DIVIDEND       = 20'd540000;
  localparam logic [15:0]        TACH_MISSING   = 16'hFFFF;
  localparam logic [19:0]        SPIN_RPM       = 20'd100;
  localparam logic [19:0]        STALL_RPM      = 20'd50;
  localparam logic [9:0]         LEVEL_MAX      = 10'd1000;
  localparam logic [11:0]        FLOOR_PER_STEP = 12'd400;
  localparam logic [10:0]        STEP_MULT      = 11'd1311;
  localparam int                 STEP_SHIFT     = 17;
  localparam logic [26:0]        DUTY_MULT      = 27'd68451180;
  localparam int                 DUTY_SHIFT     = 28;
  localparam logic signed [17:0] MDEG_PER_C     = 18'sd1000;
  localparam logic signed [7:0]  INT_LIMIT_RST  = 8'sd80;
  localparam logic signed [7:0]  EXT_LIMIT_RST  = 8'sd85;

  typedef enum logic [2:0] {
    OP_INT_TEMP,
    OP_EXT_TEMP,
    OP_TACH,
    OP_TACH_ZERO,
    OP_BUS_FAIL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] data;
  } item_t;

  typedef struct packed {
    logic [9:0]        level;
    logic signed [7:0] int_lim;
    logic signed [7:0] ext_lim;
  } cfg_t;

endpackage

// File: design/fhm_front.sv
// ----------------------------------------------------------------------------
// fhm_front
// Accepts sensor reads, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module fhm_front import fhm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [1:0]  kind,
  input  logic [15:0] read_data,
  output logic        full,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           wr, rd;
  item_t          item_in;

  always_comb begin
    item_in.data = read_data;
    case (kind)
      KIND_INT_TEMP: item_in.op = OP_INT_TEMP;
      KIND_EXT_TEMP: item_in.op = OP_EXT_TEMP;
      KIND_TACH: begin
        if (read_data == '0 || read_data == TACH_MISSING) item_in.op = OP_TACH_ZERO;
        else item_in.op = OP_TACH;
      end
      default: item_in.op = OP_BUS_FAIL;
    endcase
  end

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rptr_r];
  assign wr      = push && !full;
  assign rd      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) begin
        wptr_r <= (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (rd) begin
        rptr_r <= (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: design/fhm_divider.sv
// ----------------------------------------------------------------------------
// fhm_divider
// Restoring divider, one quotient bit per cycle: 540000 / tach count.
// ----------------------------------------------------------------------------
module fhm_divider import fhm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [19:0] quotient
);

  logic [19:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] div_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial    = {rem_r, quo_r[19]};
  assign ge       = (trial >= {1'b0, div_r});
  assign diff     = trial - {1'b0, div_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= DIVIDEND;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[18:0], ge};
      rem_r <= ge ? diff[15:0] : trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/fhm_back.sv
// ----------------------------------------------------------------------------
// fhm_back
// Carries out queued reads: keeps temperatures, speed and status flags,
// runs the speed division and holds the result register.
// ----------------------------------------------------------------------------
module fhm_back import fhm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_pop,
  output logic [19:0]        rpm,
  output logic signed [17:0] internal_temp_mdeg,
  output logic signed [17:0] external_temp_mdeg,
  output logic               over_temp,
  output logic               spinning,
  output logic               stall_res,
  output logic               no_tach,
  output logic               under_speed,
  output logic               hardware_fault,
  output logic               board_fault,
  output logic [7:0]         fan_duty,
  output logic               status_updated
);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  typedef struct packed {
    logic over_temp;
    logic spinning;
    logic stall;
    logic no_tach;
    logic under_speed;
    logic hw_fault;
    logic board_fault;
  } flags_t;

  state_t                state_r;
  logic signed [7:0]     int_r, int_nxt;
  logic signed [7:0]     ext_r, ext_nxt;
  logic [19:0]           spd_r, spd_nxt;
  flags_t                flg_r, flg_nxt;
  logic                  upd_nxt, load;
  logic                  out_valid_r;
  logic [19:0]           rpm_r;
  logic signed [17:0]    int_mdeg_r, ext_mdeg_r;
  flags_t                out_flg_r;
  logic [7:0]            duty_r, out_duty_r;
  logic                  upd_r;
  logic [3:0]            step_r;
  logic [11:0]           floor_r;
  logic [36:0]           duty_prod;
  logic [20:0]           step_prod;
  logic                  div_start, div_done;
  logic [19:0]           div_quo;

  function automatic flags_t evaluate(input flags_t f, input logic [19:0] speed,
                                      input logic signed [7:0] it,
                                      input logic signed [7:0] et,
                                      input cfg_t c, input logic [3:0] step,
                                      input logic [11:0] flr);
    flags_t r;
    logic   over;
    logic   low;
    r    = f;
    over = (it > $signed(c.int_lim)) || (et > $signed(c.ext_lim));
    low  = (speed < STALL_RPM);
    r.over_temp = over;
    r.spinning  = (speed > SPIN_RPM);
    if (c.level != '0) begin
      if (low) begin
        r.stall   = 1'b1;
        r.no_tach = 1'b1;
      end else begin
        r.stall   = 1'b0;
        r.no_tach = 1'b0;
        if (step != '0) begin
          r.under_speed = (speed < 20'(flr));
        end
      end
    end else begin
      r.stall       = 1'b0;
      r.under_speed = 1'b0;
    end
    r.board_fault = ((c.level != '0) && low) || over;
    return r;
  endfunction

  assign q_pop     = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_pop);
  assign div_start = q_pop && (q_item.op == OP_TACH);

  fhm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (q_item.data),
    .done     (div_done),
    .quotient (div_quo)
  );

  // derived config values: duty and step registered from the level, floor from the registered step
  assign duty_prod = 37'(cfg.level) * 37'(DUTY_MULT);
  assign step_prod = 21'(cfg.level) * 21'(STEP_MULT);

  always_ff @(posedge clk) begin
    duty_r  <= duty_prod[DUTY_SHIFT +: 8];
    step_r  <= step_prod[STEP_SHIFT +: 4];
    floor_r <= 12'(step_r * FLOOR_PER_STEP);
  end

  always_comb begin
    int_nxt = int_r;
    ext_nxt = ext_r;
    spd_nxt = spd_r;
    flg_nxt = flg_r;
    upd_nxt = 1'b0;
    load    = 1'b0;
    if (q_pop) begin
      case (q_item.op)
        OP_INT_TEMP: begin
          int_nxt = q_item.data[7:0];
          load    = 1'b1;
        end
        OP_EXT_TEMP: begin
          ext_nxt = q_item.data[7:0];
          load    = 1'b1;
        end
        OP_TACH_ZERO: begin
          spd_nxt = '0;
          flg_nxt = evaluate(flg_r, '0, int_r, ext_r, cfg, step_r, floor_r);
          upd_nxt = 1'b1;
          load    = 1'b1;
        end
        OP_BUS_FAIL: begin
          flg_nxt.hw_fault = 1'b1;
          load             = 1'b1;
        end
        default: ;
      endcase
    end
    if (state_r == ST_DIV && div_done) begin
      spd_nxt = div_quo;
      flg_nxt = evaluate(flg_r, div_quo, int_r, ext_r, cfg, step_r, floor_r);
      upd_nxt = 1'b1;
      load    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      int_r       <= '0;
      ext_r       <= '0;
      spd_r       <= '0;
      flg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      int_r <= int_nxt;
      ext_r <= ext_nxt;
      spd_r <= spd_nxt;
      flg_r <= flg_nxt;
      case (state_r)
        ST_IDLE: if (div_start) state_r <= ST_DIV;
        ST_DIV:  if (div_done) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rpm_r      <= spd_nxt;
      int_mdeg_r <= 18'(int_nxt * MDEG_PER_C);
      ext_mdeg_r <= 18'(ext_nxt * MDEG_PER_C);
      out_flg_r  <= flg_nxt;
      out_duty_r <= duty_r;
      upd_r      <= upd_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign rpm                = rpm_r;
  assign internal_temp_mdeg = int_mdeg_r;
  assign external_temp_mdeg = ext_mdeg_r;
  assign over_temp          = out_flg_r.over_temp;
  assign spinning           = out_flg_r.spinning;
  assign stall_res          = out_flg_r.stall;
  assign no_tach            = out_flg_r.no_tach;
  assign under_speed        = out_flg_r.under_speed;
  assign hardware_fault     = out_flg_r.hw_fault;
  assign board_fault        = out_flg_r.board_fault;
  assign fan_duty           = out_duty_r;
  assign status_updated     = upd_r;

endmodule

// File: design/fan_health_monitor.sv
// ----------------------------------------------------------------------------
// fan_health_monitor
// Fan speed and temperature health monitor, top level.
// ----------------------------------------------------------------------------
// Every accepted sensor read gives one result on the out_ queue. Temperature
// and bus-failure reads are handled in the back end once they reach the
// head of the two-entry input queue; a tach read with a usable count goes
// through the bit-serial speed divider before its result is loaded, and
// meanwhile up to two further reads can be queued. The user writes registers
// over the cfg_ port only while the block is idle; the block does not enforce
// this. A level write saturates at 1000.
module fan_health_monitor import fhm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_kind,
  input  logic [15:0]        in_read_data,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [19:0]        out_rpm,
  output logic signed [17:0] out_internal_temp_mdeg,
  output logic signed [17:0] out_external_temp_mdeg,
  output logic               out_over_temp,
  output logic               out_spinning,
  output logic               out_stall_res,
  output logic               out_no_tach,
  output logic               out_under_speed,
  output logic               out_hardware_fault,
  output logic               out_board_fault,
  output logic [7:0]         out_fan_duty,
  output logic               out_status_updated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [9:0]        level_r;
  logic signed [7:0] int_lim_r, ext_lim_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;
  cfg_t              cfg;
  logic              q_valid, q_pop, out_valid;
  item_t             q_item;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      int_lim_r <= INT_LIMIT_RST;
      ext_lim_r <= EXT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEVEL:   level_r   <= (cfg_pwdata[9:0] > LEVEL_MAX) ? LEVEL_MAX : cfg_pwdata[9:0];
        REG_INT_LIM: int_lim_r <= cfg_pwdata[7:0];
        REG_EXT_LIM: ext_lim_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEVEL:   cfg_prdata = 32'(level_r);
      REG_INT_LIM: cfg_prdata = 32'(int_lim_r);
      REG_EXT_LIM: cfg_prdata = 32'(ext_lim_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.level   = level_r;
  assign cfg.int_lim = int_lim_r;
  assign cfg.ext_lim = ext_lim_r;

  fhm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .kind      (in_kind),
    .read_data (in_read_data),
    .full      (in_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fhm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_pop            (out_pop),
    .rpm                (out_rpm),
    .internal_temp_mdeg (out_internal_temp_mdeg),
    .external_temp_mdeg (out_external_temp_mdeg),
    .over_temp          (out_over_temp),
    .spinning           (out_spinning),
    .stall_res          (out_stall_res),
    .no_tach            (out_no_tach),
    .under_speed        (out_under_speed),
    .hardware_fault     (out_hardware_fault),
    .board_fault        (out_board_fault),
    .fan_duty           (out_fan_duty),
    .status_updated     (out_status_updated)
  );

  assign out_empty = !out_valid;

endmodule

// File: design/fhm_checker.sv
// ----------------------------------------------------------------------------
// fhm_checker
// Port-level checks on the fan health monitor result stream.
// ----------------------------------------------------------------------------
module fhm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [19:0]        out_rpm,
  input logic signed [17:0] out_internal_temp_mdeg,
  input logic               out_spinning,
  input logic               out_stall_res,
  input logic               out_no_tach,
  input logic               out_hardware_fault,
  input logic               out_board_fault
);

  // a waiting transfer holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_rpm)
      && $stable(out_internal_temp_mdeg))
    else $error("result changed while waiting");

  a_stall_tach: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_stall_res |-> out_no_tach)
    else $error("stall without no_tach");

  a_stall_board: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_stall_res |-> out_board_fault)
    else $error("stall without board fault");

  a_spin_rpm: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_spinning |-> out_rpm > 20'd100)
    else $error("spinning with low speed");

  a_hw_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_hardware_fault |=> out_empty || out_hardware_fault)
    else $error("hardware fault cleared");

endmodule

bind fan_health_monitor fhm_checker u_fhm_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_empty              (out_empty),
  .out_pop                (out_pop),
  .out_rpm                (out_rpm),
  .out_internal_temp_mdeg (out_internal_temp_mdeg),
  .out_spinning           (out_spinning),
  .out_stall_res          (out_stall_res),
  .out_no_tach            (out_no_tach),
  .out_hardware_fault     (out_hardware_fault),
  .out_board_fault        (out_board_fault)
);

// File: tb/sv/fan_health_monitor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fan_health_monitor_checker
// Watches the read, result and register ports of the fan health monitor. It
// keeps its own copy of the temperatures, speed, flags and settings, works out
// the status that each accepted read must give and compares it, field by
// field, with the oldest result transfer.
// ----------------------------------------------------------------------------
module fan_health_monitor_checker import fhm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [1:0]         in_kind,
  input  logic [15:0]        in_read_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [19:0]        out_rpm,
  input  logic signed [17:0] out_internal_temp_mdeg,
  input  logic signed [17:0] out_external_temp_mdeg,
  input  logic               out_over_temp,
  input  logic               out_spinning,
  input  logic               out_stall_res,
  input  logic               out_no_tach,
  input  logic               out_under_speed,
  input  logic               out_hardware_fault,
  input  logic               out_board_fault,
  input  logic [7:0]         out_fan_duty,
  input  logic               out_status_updated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 mismatches,
  output int                 results_owed
);

  localparam int TACH_DIVIDEND      = 540000;
  localparam int SPIN_RPM_MIN       = 100;
  localparam int STALL_RPM_MIN      = 50;
  localparam int LEVEL_CAP          = 1000;
  localparam int LEVEL_PER_STEP     = 100;
  localparam int FLOOR_RPM_PER_STEP = 400;
  localparam int MDEG_SCALE         = 1000;
  localparam int DUTY_FULL          = 255;

  typedef struct packed {
    logic [19:0]        rpm;
    logic signed [17:0] int_mdeg;
    logic signed [17:0] ext_mdeg;
    logic               over_temp;
    logic               spinning;
    logic               stall;
    logic               no_tach;
    logic               under_speed;
    logic               hw_fault;
    logic               board_fault;
    logic [7:0]         duty;
    logic               updated;
  } fan_status_t;

  fan_status_t       expected_status[$];
  logic [9:0]        level;
  logic signed [7:0] int_limit;
  logic signed [7:0] ext_limit;
  logic signed [7:0] int_temp;
  logic signed [7:0] ext_temp;
  logic [19:0]       speed;
  logic              over_temp_f;
  logic              spinning_f;
  logic              stall_f;
  logic              no_tach_f;
  logic              under_speed_f;
  logic              hw_fault_f;
  logic              board_fault_f;
  int                mismatch_total = 0;

  function automatic fan_status_t apply_read(input logic [1:0] kind, input logic [15:0] data);
    fan_status_t s;
    int          step;
    s.updated = 1'b0;
    case (kind)
      KIND_INT_TEMP: int_temp = data[7:0];
      KIND_EXT_TEMP: ext_temp = data[7:0];
      KIND_TACH: begin
        speed = (data == 16'h0000 || data == 16'hFFFF) ? 20'd0 :
                20'(TACH_DIVIDEND / int'(data));
        over_temp_f = (int_temp > int_limit) || (ext_temp > ext_limit);
        spinning_f  = int'(speed) > SPIN_RPM_MIN;
        if (level != 10'd0) begin
          if (int'(speed) < STALL_RPM_MIN) begin
            stall_f   = 1'b1;
            no_tach_f = 1'b1;
          end else begin
            stall_f   = 1'b0;
            no_tach_f = 1'b0;
            step      = int'(level) / LEVEL_PER_STEP;
            if (step >= 1) begin
              under_speed_f = int'(speed) < FLOOR_RPM_PER_STEP * step;
            end
          end
        end else begin
          stall_f       = 1'b0;
          under_speed_f = 1'b0;
        end
        board_fault_f = stall_f || over_temp_f;
        s.updated     = 1'b1;
      end
      default: hw_fault_f = 1'b1;
    endcase
    s.rpm         = speed;
    s.int_mdeg    = 18'(int'(int_temp) * MDEG_SCALE);
    s.ext_mdeg    = 18'(int'(ext_temp) * MDEG_SCALE);
    s.over_temp   = over_temp_f;
    s.spinning    = spinning_f;
    s.stall       = stall_f;
    s.no_tach     = no_tach_f;
    s.under_speed = under_speed_f;
    s.hw_fault    = hw_fault_f;
    s.board_fault = board_fault_f;
    s.duty        = 8'(int'(level) * DUTY_FULL / LEVEL_CAP);
    return s;
  endfunction

  task automatic apply_reg_write(input logic [1:0] index, input logic [31:0] value);
    case (index)
      REG_LEVEL:   level = (int'(value[9:0]) > LEVEL_CAP) ? 10'(LEVEL_CAP) : value[9:0];
      REG_INT_LIM: int_limit = value[7:0];
      REG_EXT_LIM: ext_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    fan_status_t want;
    if (!rst_n) begin
      level         = '0;
      int_limit     = 8'sd80;
      ext_limit     = 8'sd85;
      int_temp      = '0;
      ext_temp      = '0;
      speed         = '0;
      over_temp_f   = 1'b0;
      spinning_f    = 1'b0;
      stall_f       = 1'b0;
      no_tach_f     = 1'b0;
      under_speed_f = 1'b0;
      hw_fault_f    = 1'b0;
      board_fault_f = 1'b0;
      expected_status.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        apply_reg_write(cfg_paddr[3:2], cfg_pwdata);
      end
      if (in_push && !in_full) begin
        expected_status.push_back(apply_read(in_kind, in_read_data));
      end
      if (out_pop && !out_empty) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual rpm %0d",
                   $time, out_rpm);
          mismatch_total++;
        end else begin
          want = expected_status.pop_front();
          check_field("rpm", want.rpm, out_rpm);
          check_field("internal_temp_mdeg", $signed(want.int_mdeg), out_internal_temp_mdeg);
          check_field("external_temp_mdeg", $signed(want.ext_mdeg), out_external_temp_mdeg);
          check_field("over_temp", want.over_temp, out_over_temp);
          check_field("spinning", want.spinning, out_spinning);
          check_field("stall_res", want.stall, out_stall_res);
          check_field("no_tach", want.no_tach, out_no_tach);
          check_field("under_speed", want.under_speed, out_under_speed);
          check_field("hardware_fault", want.hw_fault, out_hardware_fault);
          check_field("board_fault", want.board_fault, out_board_fault);
          check_field("fan_duty", want.duty, out_fan_duty);
          check_field("status_updated", want.updated, out_status_updated);
        end
      end
    end
    mismatches   <= mismatch_total;
    results_owed <= expected_status.size();
  end

endmodule

// File: tb/sv/fan_health_monitor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fan_health_monitor_test
// Drives sensor reads and register writes into the fan health monitor: a
// directed run over temperature extremes and speed thresholds, then random
// reads under several settings with random gaps on both sides, a long result
// hold-off and full drains. The checker beside the block reports mismatches.
// ----------------------------------------------------------------------------
module fan_health_monitor_test;
  import fhm_pkg::*;

  localparam int         CYCLE_LIMIT      = 500000;
  localparam int         SINK_HOLD_CYCLES = 300;
  localparam int         IDLE_PERCENT     = 32;
  localparam int         PHASE_ITEMS      = 150;
  localparam int         PHASE_COUNT      = 7;
  localparam logic [1:0] REG_SPARE        = 2'd3;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_push      = 1'b0;
  logic [1:0]         in_kind      = KIND_INT_TEMP;
  logic [15:0]        in_read_data = '0;
  logic               out_pop      = 1'b0;
  logic               cfg_psel     = 1'b0;
  logic               cfg_penable  = 1'b0;
  logic               cfg_pwrite   = 1'b0;
  logic [3:0]         cfg_paddr    = '0;
  logic [31:0]        cfg_pwdata   = '0;
  logic               in_full;
  logic               out_empty;
  logic [19:0]        out_rpm;
  logic signed [17:0] out_internal_temp_mdeg;
  logic signed [17:0] out_external_temp_mdeg;
  logic               out_over_temp;
  logic               out_spinning;
  logic               out_stall_res;
  logic               out_no_tach;
  logic               out_under_speed;
  logic               out_hardware_fault;
  logic               out_board_fault;
  logic [7:0]         out_fan_duty;
  logic               out_status_updated;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 mismatches;
  int                 results_owed;

  logic               idle_on       = 1'b1;
  int                 hold_requests = 0;
  int                 cycle_count   = 0;
  logic signed [7:0]  cur_int_lim   = 8'sd80;
  logic signed [7:0]  cur_ext_lim   = 8'sd85;

  fan_health_monitor u_top (.*);

  fan_health_monitor_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random gaps, plus long hold-offs on request
  initial begin : sink
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && served != hold_requests) begin
        served++;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  task automatic send(input logic [1:0] kind, input logic [15:0] data);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_kind      <= kind;
    in_read_data <= data;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int level, input int int_lim, input int ext_lim);
    drain();
    reg_write(REG_LEVEL, 32'(level));
    reg_write(REG_INT_LIM, 32'(int_lim));
    reg_write(REG_EXT_LIM, 32'(ext_lim));
    cur_int_lim = 8'(int_lim);
    cur_ext_lim = 8'(ext_lim);
  endtask

  // counts around the stall, spin and under-speed thresholds, plus edge counts
  function automatic logic [15:0] rand_tach();
    int pick;
    int target;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        2:       return 16'h0001;
        default: return 16'h0002;
      endcase
    end
    if (pick < 45) begin
      case ($urandom_range(2))
        0:       target = 50;
        1:       target = 100;
        default: target = 400 * int'($urandom_range(1, 10));
      endcase
      return 16'(540000 / target + int'($urandom_range(2)) - 1);
    end
    if (pick < 75) return 16'($urandom_range(100, 12000));
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] rand_temp(input logic signed [7:0] limit);
    logic [7:0] deg;
    if ($urandom_range(1) == 1) begin
      deg = 8'($urandom_range(255));
    end else begin
      deg = 8'(int'(limit) + int'($urandom_range(2)) - 1);
    end
    return {8'($urandom_range(255)), deg};
  endfunction

  task automatic random_phase(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        send(KIND_INT_TEMP, rand_temp(cur_int_lim));
      end else if (pick < 44) begin
        send(KIND_EXT_TEMP, rand_temp(cur_ext_lim));
      end else if (pick < 95) begin
        send(KIND_TACH, rand_tach());
      end else begin
        send(KIND_BUS_FAIL, 16'($urandom_range(65535)));
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits, drive off: temperature extremes, unusable counts and a count of one
    send(KIND_INT_TEMP, 16'h007F);
    send(KIND_EXT_TEMP, 16'hAB80);
    send(KIND_TACH, 16'h0000);
    send(KIND_INT_TEMP, 16'hFF50);
    send(KIND_EXT_TEMP, 16'h0055);
    send(KIND_TACH, 16'hFFFF);
    send(KIND_TACH, 16'h0001);

    // oversized level saturates, limits at their extremes
    configure(1023, -128, 127);
    send(KIND_TACH, 16'd5400);
    send(KIND_TACH, 16'd5346);
    send(KIND_TACH, 16'd10800);
    send(KIND_TACH, 16'd10801);
    send(KIND_INT_TEMP, 16'h0080);
    send(KIND_EXT_TEMP, 16'h007F);
    send(KIND_TACH, 16'd135);
    send(KIND_TACH, 16'd136);

    configure(0, -128, 127);
    send(KIND_TACH, 16'h0000);
    send(KIND_TACH, 16'd540);

    // level below one step leaves under-speed alone
    configure(99, 0, 0);
    send(KIND_TACH, 16'd10801);
    send(KIND_TACH, 16'd2000);

    configure(550, 0, 0);
    send(KIND_TACH, 16'd270);
    send(KIND_TACH, 16'd271);
    send(KIND_BUS_FAIL, 16'hFFFF);
    send(KIND_INT_TEMP, 16'h0001);
    send(KIND_TACH, 16'd270);

    // write to an unused register index is ignored
    drain();
    reg_write(REG_SPARE, 32'h0000_03FF);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       configure(1000, 80, 85);
        2:       configure(0, 127, -128);
        3:       configure(400, 40, 45);
        4:       configure(1023, -128, -128);
        5:       configure(100, 127, 127);
        default: configure($urandom_range(1023), int'($urandom_range(255)) - 128,
                           int'($urandom_range(255)) - 128);
      endcase
      idle_on <= (phase != 0);
      if (phase == 3) begin
        hold_requests <= hold_requests + 1;
      end
      random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fhm_pkg.sv
design/fhm_front.sv
design/fhm_divider.sv
design/fhm_back.sv
design/fan_health_monitor.sv
design/fhm_checker.sv
tb/sv/fan_health_monitor_checker.sv
tb/sv/fan_health_monitor_test.sv
